@@ hw/rtl/ic3_pkg.sv @@
`default_nettype none

package ic3_pkg;

    localparam int PIX_W        = 8;
    localparam int POS_W        = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int FRAME_SIZE_W = 11;

    localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 11'd1024;
    localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_MIN   = 11'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE  = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_in_req;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [PIX_W-1:0] out_value;
        logic             frame_last;
    } t_out_req;

endpackage

`default_nettype wire

@@ hw/rtl/image_convolution_3x3.sv @@
`default_nettype none

// 3x3 convolution over a square 8-bit frame streamed in raster order. One pixel
// is taken per clock while o_in_stall is low; each one does a read-modify-write
// of a single line-store RAM entry (previous two rows side by side), with a
// bypass when the same column is touched on consecutive pixels. The result for
// interior pixel (r-1,c-1) passes from pixel (r,c) through the read, window,
// product and row-sum registers into an 8-entry output queue; the input stalls
// once eight results are outstanding. After reset the line store is cleared
// one entry per cycle, all MAX_SIZE entries, while o_in_stall stays high;
// configuration writes are taken at any time. Coefficients and frame_size must only change while the block is idle.
module image_convolution_3x3 #(
    parameter int MAX_SIZE = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ic3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ic3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_stall,
    input  wire ic3_pkg::t_in_req               i_in_data,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    output      ic3_pkg::t_out_req              o_out_data
);

    localparam int CW      = $clog2(MAX_SIZE);
    localparam int SW      = CW + 1;
    localparam int ZW      = (SW > ic3_pkg::FRAME_SIZE_W) ? SW : ic3_pkg::FRAME_SIZE_W;
    localparam int PW      = ic3_pkg::PIX_W;
    localparam int FIFO_D  = 8;
    localparam int FPW     = $clog2(FIFO_D);
    localparam int FCW     = FPW + 1;

    // configuration
    logic [ic3_pkg::CFG_DATA_W-1:0]   r_coef [3];
    logic [ic3_pkg::FRAME_SIZE_W-1:0] r_frame_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0]    <= '0;
            r_coef[1]    <= '0;
            r_coef[2]    <= '0;
            r_frame_size <= ic3_pkg::FRAME_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ic3_pkg::CFG_COEF_TOP:    r_coef[0]    <= i_cfg_data;
                ic3_pkg::CFG_COEF_MID:    r_coef[1]    <= i_cfg_data;
                ic3_pkg::CFG_COEF_BOTTOM: r_coef[2]    <= i_cfg_data;
                ic3_pkg::CFG_FRAME_SIZE:
                    r_frame_size <= i_cfg_data[ic3_pkg::FRAME_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [ZW-1:0] fs_z;
    logic [ZW-1:0] size_z;
    logic [SW-1:0] size;

    always_comb begin
        fs_z = ZW'(r_frame_size);
        if (fs_z < ZW'(ic3_pkg::FRAME_SIZE_MIN)) begin
            size_z = ZW'(ic3_pkg::FRAME_SIZE_MIN);
        end else if (fs_z > ZW'(MAX_SIZE)) begin
            size_z = ZW'(MAX_SIZE);
        end else begin
            size_z = fs_z;
        end
        size = SW'(size_z);
    end

    // clearing pass, credit and accept
    logic              r_clr_busy;
    logic [CW-1:0]     r_clr_addr;
    logic [FCW-1:0]    r_credit;
    logic              in_acc;
    logic              out_pop;

    assign o_in_stall = r_clr_busy || (r_credit >= FCW'(FIFO_D));
    assign in_acc     = i_in_valid && !o_in_stall;

    // position counters
    logic [CW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] row_cur;
    logic [CW-1:0] col_cur;
    logic [SW-1:0] row_inc;
    logic [SW-1:0] col_inc;
    logic [CW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic          produce;
    logic          last;

    always_comb begin
        row_cur = i_in_data.frame_start ? '0 : r_row;
        col_cur = i_in_data.frame_start ? '0 : r_col;
        row_inc = {1'b0, row_cur} + SW'(1);
        col_inc = {1'b0, col_cur} + SW'(1);
        produce = (row_cur >= CW'(2)) && (col_cur >= CW'(2));
        last    = ({1'b0, row_cur} == size - SW'(1)) && ({1'b0, col_cur} == size - SW'(1));
        if (col_inc >= size) begin
            n_col = '0;
            n_row = (row_inc >= size) ? '0 : row_inc[CW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = row_cur;
        end
    end

    // stage 1: line-store read data
    logic                    r_s1_valid;
    logic                    r_s1_prod;
    logic [CW-1:0]           r_s1_addr;
    logic [PW-1:0]           r_s1_px;
    logic                    r_s1_fwd;
    logic [PW-1:0]           r_s1_fwd_a;
    logic [PW-1:0]           r_s1_fwd_b;
    ic3_pkg::t_out_req       r_s1_meta;
    logic [2*PW-1:0]         ram_rdata;
    logic [PW-1:0]           a_eff;
    logic [PW-1:0]           b_eff;
    logic                    ram_we;
    logic [CW-1:0]           ram_waddr;
    logic [2*PW-1:0]         ram_wdata;

    assign a_eff = r_s1_fwd ? r_s1_fwd_a : ram_rdata[2*PW-1:PW];
    assign b_eff = r_s1_fwd ? r_s1_fwd_b : ram_rdata[PW-1:0];

    assign ram_we    = r_clr_busy || r_s1_valid;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : {r_s1_px, a_eff};

    ic3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_SIZE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    // window and later stages
    logic [PW-1:0]           r_win [9];
    logic                    r_s2_valid;
    ic3_pkg::t_out_req       r_s2_meta;
    logic                    r_s3_valid;
    ic3_pkg::t_out_req       r_s3_meta;
    logic signed [16:0]      r_prod [9];
    logic                    r_s4_valid;
    ic3_pkg::t_out_req       r_s4_meta;
    logic signed [18:0]      r_rsum [3];
    logic signed [19:0]      total;
    logic [PW-1:0]           clamped;
    ic3_pkg::t_out_req       fifo_wdata;

    always_comb begin
        total = 20'(r_rsum[0]) + 20'(r_rsum[1]) + 20'(r_rsum[2]);
        if (total < 0) begin
            clamped = '0;
        end else if (total > 20'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = total[PW-1:0];
        end
        fifo_wdata           = r_s4_meta;
        fifo_wdata.out_value = clamped;
    end

    // output queue
    ic3_pkg::t_out_req r_fifo [FIFO_D];
    logic [FPW-1:0]    r_wptr;
    logic [FPW-1:0]    r_rptr;
    logic [FCW-1:0]    r_count;
    logic [FCW-1:0]    n_credit;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rptr];
    assign out_pop     = o_out_valid && !i_out_stall;

    always_comb begin
        n_credit = r_credit;
        if (in_acc && produce) begin
            n_credit = n_credit + FCW'(1);
        end
        if (out_pop) begin
            n_credit = n_credit - FCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_credit   <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_prod  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_count    <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(MAX_SIZE - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_credit <= n_credit;

            if (in_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_s1_valid <= in_acc;
            r_s1_prod  <= in_acc && produce;

            if (r_s1_valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= b_eff;
                r_win[5] <= a_eff;
                r_win[8] <= r_s1_px;
            end
            r_s2_valid <= r_s1_prod;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;

            if (r_s4_valid) begin
                r_wptr <= r_wptr + FPW'(1);
            end
            if (out_pop) begin
                r_rptr <= r_rptr + FPW'(1);
            end
            r_count <= r_count + FCW'(r_s4_valid) - FCW'(out_pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr            <= col_cur;
            r_s1_px              <= i_in_data.pixel;
            r_s1_fwd             <= r_s1_valid && (r_s1_addr == col_cur);
            r_s1_fwd_a           <= r_s1_px;
            r_s1_fwd_b           <= a_eff;
            r_s1_meta.out_row    <= ic3_pkg::POS_W'(row_cur - CW'(1));
            r_s1_meta.out_col    <= ic3_pkg::POS_W'(col_cur - CW'(1));
            r_s1_meta.out_value  <= '0;
            r_s1_meta.frame_last <= last;
        end
        r_s2_meta <= r_s1_meta;
        r_s3_meta <= r_s2_meta;
        r_s4_meta <= r_s3_meta;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                r_prod[k*3+m] <= $signed({1'b0, r_win[k*3+m]})
                               * $signed(r_coef[k][8*m +: 8]);
            end
            r_rsum[k] <= 19'(r_prod[k*3]) + 19'(r_prod[k*3+1]) + 19'(r_prod[k*3+2]);
        end
        if (r_s4_valid) begin
            r_fifo[r_wptr] <= fifo_wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ic3_ram.sv @@
`default_nettype none

module ic3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
